FILE: sv/chebyshev_waveshaper_distortion_macros.svh
// Assertion macros for the waveshaper RTL.
// Included by cwd_ctrl, which carries the concurrent checks; needs a clk and rst in scope.
`ifndef CHEBYSHEV_WAVESHAPER_DISTORTION_MACROS_SVH
`define CHEBYSHEV_WAVESHAPER_DISTORTION_MACROS_SVH

// checked only outside reset
`define CWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define CWD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cwd_pkg.sv
// Shared types and constants for the Chebyshev waveshaper.
// No dependencies; used by the controller, the datapath and the top level.
package cwd_pkg;

  // multiplier operand selection
  typedef enum logic [2:0] {
    M_NONE,
    M_ENV_KEEP,
    M_A_NEW,
    M_ENV_DRV,
    M_W0,
    M_W1,
    M_HORNER,
    M_DC
  } mul_sel_t;

  // what the datapath does with the registered product and its state
  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_SAVE_T,
    A_ENV_UPD,
    A_ED,
    A_W_STORE,
    A_CHEB_INIT,
    A_CHEB_STEP,
    A_CHEB_FIN,
    A_H_INIT,
    A_H_STEP,
    A_DC,
    A_OUT
  } act_t;

  typedef struct packed {
    mul_sel_t mul;
    act_t     act;
  } cwd_cmd_t;

  localparam logic [16:0] ATK_KEEP = 17'd58982;
  localparam logic [16:0] ATK_NEW  = 17'd6554;
  localparam logic [16:0] REL_KEEP = 17'd63570;
  localparam logic [16:0] REL_NEW  = 17'd1966;
  localparam logic [25:0] DC_POLE  = 26'd16760439;
  localparam logic [15:0] W_UNIT   = 16'd32768;

  // row with harmonics 1/i, Q1.15
  localparam logic [15:0] HARM_ROW1 [16] = '{
    16'd0, 16'd32768, 16'd16384, 16'd10923, 16'd8192, 16'd6554, 16'd5461, 16'd4681,
    16'd4096, 16'd3641, 16'd3277, 16'd2979, 16'd2731, 16'd2521, 16'd2341, 16'd2185
  };

endpackage

FILE: sv/cwd_if.sv
// Stream interfaces for the waveshaper sample channels.
// Valid/ready handshake; width follows the sample size. No dependencies.
interface cwd_in_if #(parameter int SAMPLE_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   end_of_block;
  modport source (output valid, output sample_in, output end_of_block, input ready);
  modport sink   (input valid, input sample_in, input end_of_block, output ready);
endinterface

interface cwd_out_if #(parameter int SAMPLE_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   end_of_block_out;
  modport source (output valid, output sample_out, output end_of_block_out, input ready);
  modport sink   (input valid, input sample_out, input end_of_block_out, output ready);
endinterface

FILE: sv/chebyshev_waveshaper_distortion.sv
// Chebyshev waveshaper with envelope-driven harmonic mix and DC blocker.
// One sample in, one sample out. On the first sample after reset and every
// RECOMPUTE_GAP+1 samples after it, the weight mix and power-series
// conversion run before the output is formed; other samples skip them.
// All multiplies go through a single shared multiplier, which is registered;
// the conversion steps one order at a time.
// A finished result waits in the output register while the next sample is taken.
// drive may only be written while the block is idle. Depends on cwd_pkg, cwd_if,
// cwd_ctrl and cwd_datapath.
module chebyshev_waveshaper_distortion import cwd_pkg::*; #(
  parameter int NUM_HARMONICS = 11,
  parameter int SAMPLE_BITS   = 24,
  parameter int RECOMPUTE_GAP = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  cwd_in_if.sink      in_stream,
  cwd_out_if.source   out_stream
);

  localparam int IW = $clog2(NUM_HARMONICS);

  cwd_cmd_t      cmd;
  logic [IW-1:0] idx;

  cwd_ctrl #(
    .NUM_HARMONICS (NUM_HARMONICS),
    .RECOMPUTE_GAP (RECOMPUTE_GAP)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_ready (out_stream.ready),
    .out_valid (out_stream.valid),
    .cmd       (cmd),
    .idx       (idx)
  );

  cwd_datapath #(
    .NUM_HARMONICS (NUM_HARMONICS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .idx              (idx),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .sample_in        (in_stream.sample_in),
    .end_of_block     (in_stream.end_of_block),
    .sample_out       (out_stream.sample_out),
    .end_of_block_out (out_stream.end_of_block_out)
  );

endmodule

FILE: sv/cwd_ctrl.sv
// Sequencer for the waveshaper: issues one command per cycle to the datapath.
// Depends on cwd_pkg and the assertion macro header.
`include "chebyshev_waveshaper_distortion_macros.svh"
module cwd_ctrl import cwd_pkg::*; #(
  parameter int NUM_HARMONICS = 11,
  parameter int RECOMPUTE_GAP = 4,
  localparam int IW = $clog2(NUM_HARMONICS),
  localparam int CW = (RECOMPUTE_GAP > 0) ? $clog2(RECOMPUTE_GAP + 1) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output cwd_cmd_t      cmd,
  output logic [IW-1:0] idx
);

  typedef enum logic [4:0] {
    S_IDLE, S_ENV1, S_ENV2, S_ENV3, S_ED1, S_ED2, S_W0, S_W1, S_WS,
    S_CINIT, S_CSTEP, S_CFIN, S_HINIT, S_HMUL, S_HADD, S_DC1, S_DC2, S_OUT
  } state_t;

  state_t        state;
  logic [CW-1:0] countdown;
  logic          out_go;

  assign in_ready = (state == S_IDLE);
  assign out_go   = !out_valid || out_ready;

  always_comb begin
    cmd = '{mul: M_NONE, act: A_NONE};
    case (state)
      S_IDLE:  cmd.act = in_valid ? A_LOAD : A_NONE;
      S_ENV1:  cmd.mul = M_ENV_KEEP;
      S_ENV2:  cmd = '{mul: M_A_NEW, act: A_SAVE_T};
      S_ENV3:  cmd.act = A_ENV_UPD;
      S_ED1:   cmd.mul = M_ENV_DRV;
      S_ED2:   cmd.act = A_ED;
      S_W0:    cmd.mul = M_W0;
      S_W1:    cmd = '{mul: M_W1, act: A_SAVE_T};
      S_WS:    cmd.act = A_W_STORE;
      S_CINIT: cmd.act = A_CHEB_INIT;
      S_CSTEP: cmd.act = A_CHEB_STEP;
      S_CFIN:  cmd.act = A_CHEB_FIN;
      S_HINIT: cmd.act = A_H_INIT;
      S_HMUL:  cmd.mul = M_HORNER;
      S_HADD:  cmd.act = A_H_STEP;
      S_DC1:   cmd.mul = M_DC;
      S_DC2:   cmd.act = A_DC;
      S_OUT:   cmd.act = out_go ? A_OUT : A_NONE;
      default: cmd = '{mul: M_NONE, act: A_NONE};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      countdown <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      // in the output step a taken beat is replaced by the new one below
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE:  if (in_valid) state <= S_ENV1;
        S_ENV1:  state <= S_ENV2;
        S_ENV2:  state <= S_ENV3;
        S_ENV3: begin
          if (countdown == '0) begin
            countdown <= CW'(RECOMPUTE_GAP);
            state     <= S_ED1;
          end else begin
            countdown <= countdown - 1'b1;
            state     <= S_HINIT;
          end
        end
        S_ED1:   state <= S_ED2;
        S_ED2: begin
          idx   <= '0;
          state <= S_W0;
        end
        S_W0:    state <= S_W1;
        S_W1:    state <= S_WS;
        S_WS: begin
          if (idx == IW'(NUM_HARMONICS - 1)) begin
            state <= S_CINIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_W0;
          end
        end
        S_CINIT: begin
          idx   <= IW'(NUM_HARMONICS - 2);
          state <= (NUM_HARMONICS > 2) ? S_CSTEP : S_CFIN;
        end
        S_CSTEP: begin
          if (idx == IW'(1)) state <= S_CFIN;
          else idx <= idx - 1'b1;
        end
        S_CFIN:  state <= S_HINIT;
        S_HINIT: begin
          idx   <= IW'(NUM_HARMONICS - 2);
          state <= S_HMUL;
        end
        S_HMUL:  state <= S_HADD;
        S_HADD: begin
          if (idx == '0) begin
            state <= S_DC1;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_HMUL;
          end
        end
        S_DC1:   state <= S_DC2;
        S_DC2:   state <= S_OUT;
        S_OUT: begin
          if (out_go) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CWD_ASSERT(a_out_from_seq, $rose(out_valid) |-> $past(state) == S_OUT, "result beat raised outside output step")
  `CWD_ASSERT(a_countdown_rng, countdown <= CW'(RECOMPUTE_GAP), "recompute countdown out of range")
  `CWD_ASSERT(a_accept_starts, (in_valid && in_ready) |=> state == S_ENV1, "accepted beat did not start envelope")

endmodule

FILE: sv/cwd_datapath.sv
// Datapath of the waveshaper: shared multiplier, envelope, weight mix,
// Chebyshev conversion lanes, Horner accumulator, DC blocker. Uses cwd_pkg.
module cwd_datapath import cwd_pkg::*; #(
  parameter int NUM_HARMONICS = 11,
  parameter int SAMPLE_BITS   = 24,
  localparam int IW = $clog2(NUM_HARMONICS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cwd_cmd_t               cmd,
  input  logic [IW-1:0]          idx,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic                   end_of_block,
  output logic [SAMPLE_BITS-1:0] sample_out,
  output logic                   end_of_block_out
);

  localparam int SB     = SAMPLE_BITS;
  localparam int NH     = NUM_HARMONICS;
  localparam int MW     = (SB + 2 > 33) ? SB + 2 : 33;
  localparam int PW     = 2 * MW;
  localparam int ED_W   = 28;
  localparam int OUT_SH = (SB < 25) ? 25 - SB : 0;
  localparam int OUT_UP = (SB > 25) ? SB - 25 : 0;
  localparam logic signed [PW-1:0] I32MAX = {{(PW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [PW-1:0] I32MIN = ~I32MAX;
  localparam logic signed [PW-1:0] SMAX   = {{(PW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN   = ~SMAX;

  // round to nearest, halves away from zero
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int s);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    if (s == 0) return v;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    r = (m + (PW'(1) << (s - 1))) >> s;
    return v[PW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (v > I32MAX) return 32'sh7fffffff;
    if (v < I32MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [15:0]              drive;
  logic signed [SB-1:0]     x;
  logic                     eob;
  logic [SB-1:0]            mag;
  logic [SB-1:0]            env;
  logic [ED_W-1:0]          ed;
  logic signed [PW-1:0]     t;
  logic signed [PW-1:0]     prod;
  logic signed [MW-1:0]     ma, mb;
  logic signed [29:0]       one_minus_ed;
  logic signed [31:0]       acc;
  logic signed [31:0]       prev;
  logic signed [31:0]       dcout;
  logic signed [31:0]       c    [NH];
  logic signed [63:0]       d    [NH];
  logic signed [63:0]       dd   [NH];
  logic signed [31:0]       pc   [NH];
  logic signed [31:0]       fin  [NH];
  logic signed [PW-1:0]     sum_t, h_next, dc_next, out_w;
  logic [PW-1:0]            env_sum;
  logic signed [63:0]       fin0;

  assign mag          = x[SB-1] ? SB'(-x) : SB'(x);
  assign one_minus_ed = 30'sh1000000 - $signed({2'b00, ed});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul)
      M_ENV_KEEP: begin
        ma = MW'($signed({1'b0, env}));
        mb = MW'($signed(mag > env ? ATK_KEEP : REL_KEEP));
      end
      M_A_NEW: begin
        ma = MW'($signed({1'b0, mag}));
        mb = MW'($signed(mag > env ? ATK_NEW : REL_NEW));
      end
      M_ENV_DRV: begin
        ma = MW'($signed({1'b0, env}));
        mb = MW'($signed({1'b0, drive}));
      end
      M_W0: begin
        ma = MW'($signed({1'b0, (idx == IW'(1)) ? W_UNIT : 16'd0}));
        mb = MW'(one_minus_ed);
      end
      M_W1: begin
        ma = MW'($signed({1'b0, HARM_ROW1[4'(idx)]}));
        mb = MW'($signed({1'b0, ed}));
      end
      M_HORNER: begin
        ma = MW'(acc);
        mb = MW'(x);
      end
      M_DC: begin
        ma = MW'(dcout);
        mb = MW'($signed(DC_POLE));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    sum_t   = t + prod;
    env_sum = PW'(sum_t) + PW'(32768);
    h_next  = PW'(pc[idx]) + rnd(prod, SB - 1);
    dc_next = rnd(prod, 24) + PW'(acc) - PW'(prev);
    out_w   = rnd(PW'(dcout), OUT_SH) <<< OUT_UP;
    fin0    = 64'(rnd(PW'(c[0]), 1)) - dd[0];
    fin[0]  = sat32(PW'(fin0));
    for (int k = 1; k < NH; k++) begin
      fin[k] = sat32(PW'(d[k-1] - dd[k]));
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.act)
      A_LOAD: begin
        x   <= $signed(sample_in);
        eob <= end_of_block;
      end
      A_SAVE_T:  t  <= prod;
      A_ED:      ed <= ED_W'(rnd(prod, SB - 13));
      A_W_STORE: c[idx] <= 32'(rnd(sum_t, 15));
      A_CHEB_INIT: begin
        for (int k = 1; k < NH; k++) begin
          d[k]  <= '0;
          dd[k] <= '0;
        end
        d[0]  <= 64'(c[NH-1]);
        dd[0] <= '0;
      end
      A_CHEB_STEP: begin
        // lanes above NH - idx stay put
        for (int k = 1; k < NH; k++) begin
          if (k <= NH - int'(idx)) begin
            d[k]  <= (d[k-1] <<< 1) - dd[k];
            dd[k] <= d[k];
          end
        end
        d[0]  <= 64'(c[idx]) - dd[0];
        dd[0] <= d[0];
      end
      A_CHEB_FIN: begin
        for (int k = 0; k < NH; k++) pc[k] <= fin[k];
      end
      A_H_INIT:  acc <= pc[NH-1];
      A_H_STEP:  acc <= sat32(h_next);
      A_OUT: begin
        if (out_w > SMAX)      sample_out <= SMAX[SB-1:0];
        else if (out_w < SMIN) sample_out <= SMIN[SB-1:0];
        else                   sample_out <= out_w[SB-1:0];
        end_of_block_out <= eob;
      end
      default: ;
    endcase

    if (rst) begin
      env   <= '0;
      prev  <= '0;
      dcout <= '0;
      drive <= '0;
    end else begin
      if (cfg_we) drive <= cfg_wdata;
      if (cmd.act == A_ENV_UPD) env <= env_sum[SB+15:16];
      if (cmd.act == A_DC) begin
        dcout <= sat32(dc_next);
        prev  <= acc;
      end
    end
  end

endmodule
